FILE: rtl/core/rsml_pkg.sv
// Package for the range set merge and lookup unit.
// Holds request/result structs, command and status codes, and size constants.
// No dependencies.
package rsml_pkg;

  localparam int MaxRangesDefault = 64;
  localparam int ValueBits = 16;
  localparam int FieldBits = ValueBits;
  localparam int CountBits = 7;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  typedef struct packed {
    logic [1:0]           command;
    logic [FieldBits-1:0] range_first;
    logic [FieldBits-1:0] range_last;
    logic [FieldBits-1:0] query_value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 is_member;
    logic [CountBits-1:0] range_count;
  } rsp_t;

endpackage

FILE: rtl/core/range_set_merge_lookup_unit.sv
// Range set merge and lookup unit: a sorted range table over one shared comparator.
// Depends on rsml_pkg. Add: checks the range against the limits, then appends it to the pending table.
// Query: scans the committed ranges in order and stops at the first start above the value.
// Commit: copies the committed and pending ranges, insertion-sorts the copy, then merges it.
// One request at a time; in_stall stays high until the result has been taken.
// Synchronous active-high reset clears counts, limits and control; tables need none.
module range_set_merge_lookup_unit #(
  parameter int MAX_RANGES = rsml_pkg::MaxRangesDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rsml_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rsml_pkg::rsp_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [rsml_pkg::ValueBits-1:0] cfg_data
);
  import rsml_pkg::*;

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int VB = ValueBits;
  localparam logic [VB-1:0] TOP = {VB{1'b1}};

  localparam logic [4:0] S_IDLE = 5'd0, S_ADD = 5'd1, S_QRD = 5'd2, S_QCMP = 5'd3,
    S_QEND = 5'd4, S_CPY = 5'd5, S_CPYR = 5'd6, S_CPYW = 5'd7, S_SIN = 5'd8,
    S_SKEY = 5'd9, S_SOUT = 5'd10, S_SCMP = 5'd11, S_MRD = 5'd12, S_MCMP = 5'd13,
    S_MMAX = 5'd14, S_MEND = 5'd15, S_DONE = 5'd16, S_OUT = 5'd17;

  logic [4:0] state;
  logic [VB-1:0] lower_limit, upper_limit;
  logic [CW-1:0] committed_count, pending_count;
  req_t req;
  rsp_t rsp;

  // Committed and pending tables, plus a work table for the sort.
  logic [2*VB-1:0] cmem [MAX_RANGES];
  logic [2*VB-1:0] pmem [MAX_RANGES];
  logic [2*VB-1:0] wmem [MAX_RANGES];
  logic [2*VB-1:0] crd, prd, wrd;
  logic [IW-1:0] craddr, praddr, wraddr;

  logic [CW-1:0] i, j, n, out_idx;
  logic [VB-1:0] key_s, key_e, cur_s, cur_e;
  logic member;

  logic [VB-1:0] qv, first, last;
  assign qv = req.query_value[VB-1:0];
  assign first = req.range_first[VB-1:0];
  assign last = req.range_last[VB-1:0];

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = rsp;

  // The copy reads entry i of the joined committed-then-pending list; the sort
  // reads the neighbor below the insertion point.
  assign craddr = i[IW-1:0];
  assign praddr = IW'(i - committed_count);
  assign wraddr = (state == S_SOUT) ? IW'(j - 1'b1) : i[IW-1:0];

  // Shared compare unit: a <= b.
  logic [VB-1:0] ca, cb;
  logic le;
  assign le = (ca <= cb);

  logic [CW:0] total;
  assign total = {1'b0, committed_count} + {1'b0, pending_count};

  always_comb begin
    ca = '0;
    cb = '0;
    unique case (state)
      S_QCMP: begin ca = crd[2*VB-1:VB]; cb = qv; end
      S_QEND: begin ca = qv; cb = crd[VB-1:0]; end
      S_SCMP: begin ca = wrd[2*VB-1:VB]; cb = key_s; end
      S_MCMP: begin ca = wrd[2*VB-1:VB]; cb = cur_e + 1'b1; end
      S_MMAX: begin ca = wrd[VB-1:0]; cb = cur_e; end
      default: begin ca = '0; cb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    crd <= cmem[craddr];
    prd <= pmem[praddr];
    wrd <= wmem[wraddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lower_limit <= '0;
      upper_limit <= TOP;
      committed_count <= '0;
      pending_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LOWER) lower_limit <= cfg_data[VB-1:0];
        else upper_limit <= cfg_data[VB-1:0];
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          req <= in_data;
          rsp <= '0;
          i <= '0;
          member <= 1'b0;
          unique case (in_data.command)
            CMD_ADD:    state <= S_ADD;
            CMD_COMMIT: state <= S_CPY;
            CMD_QUERY:  state <= S_QRD;
            default:    state <= S_DONE;
          endcase
        end
        S_ADD: begin
          if (last < first || (lower_limit != '0 && first < lower_limit) ||
              (upper_limit != TOP && last > upper_limit)) rsp.status <= ST_BAD;
          else if (total >= (CW+1)'(MAX_RANGES)) rsp.status <= ST_FULL;
          else begin
            pmem[pending_count[IW-1:0]] <= {first, last};
            pending_count <= pending_count + 1'b1;
          end
          state <= S_DONE;
        end
        S_QRD: begin
          if (i == committed_count) state <= S_DONE;
          else state <= S_QCMP;
        end
        // The committed table is sorted and disjoint, so a start above the
        // value ends the search.
        S_QCMP: begin
          if (le) state <= S_QEND;
          else state <= S_DONE;
        end
        S_QEND: begin
          if (le) begin
            member <= 1'b1;
            state <= S_DONE;
          end else begin
            i <= i + 1'b1;
            state <= S_QRD;
          end
        end
        S_CPY: begin
          n <= total[CW-1:0];
          if (total == '0) state <= S_DONE;
          else state <= S_CPYR;
        end
        S_CPYR: state <= S_CPYW;
        S_CPYW: begin
          wmem[i[IW-1:0]] <= (i < committed_count) ? crd : prd;
          if (i + 1'b1 == n) begin
            if (n == CW'(1)) begin
              i <= '0;
              state <= S_MRD;
            end else begin
              i <= CW'(1);
              state <= S_SIN;
            end
          end else begin
            i <= i + 1'b1;
            state <= S_CPYR;
          end
        end
        S_SIN: state <= S_SKEY;
        S_SKEY: begin
          key_s <= wrd[2*VB-1:VB];
          key_e <= wrd[VB-1:0];
          j <= i;
          state <= S_SOUT;
        end
        S_SOUT: begin
          if (j == '0) begin
            wmem[j[IW-1:0]] <= {key_s, key_e};
            if (i + 1'b1 == n) begin
              i <= '0;
              state <= S_MRD;
            end else begin
              i <= i + 1'b1;
              state <= S_SIN;
            end
          end else state <= S_SCMP;
        end
        // Shift the lower neighbor up while its start is above the key.
        S_SCMP: begin
          if (le) begin
            wmem[j[IW-1:0]] <= {key_s, key_e};
            if (i + 1'b1 == n) begin
              i <= '0;
              state <= S_MRD;
            end else begin
              i <= i + 1'b1;
              state <= S_SIN;
            end
          end else begin
            wmem[j[IW-1:0]] <= wrd;
            j <= j - 1'b1;
            state <= S_SOUT;
          end
        end
        S_MRD: state <= S_MCMP;
        // Ranges that overlap or touch join the open range; one ending at the
        // top value absorbs everything after it.
        S_MCMP: begin
          if (i == '0 || !(cur_e == TOP || le)) begin
            if (i != '0) begin
              cmem[out_idx[IW-1:0]] <= {cur_s, cur_e};
              out_idx <= out_idx + 1'b1;
            end else out_idx <= '0;
            cur_s <= wrd[2*VB-1:VB];
            cur_e <= wrd[VB-1:0];
            if (i + 1'b1 == n) state <= S_MEND;
            else begin
              i <= i + 1'b1;
              state <= S_MRD;
            end
          end else state <= S_MMAX;
        end
        S_MMAX: begin
          if (!le) cur_e <= wrd[VB-1:0];
          if (i + 1'b1 == n) state <= S_MEND;
          else begin
            i <= i + 1'b1;
            state <= S_MRD;
          end
        end
        S_MEND: begin
          cmem[out_idx[IW-1:0]] <= {cur_s, cur_e};
          committed_count <= out_idx + 1'b1;
          pending_count <= '0;
          state <= S_DONE;
        end
        S_DONE: begin
          rsp.is_member <= member;
          rsp.range_count <= CountBits'(total);
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data));
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall);
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    total <= (CW+1)'(MAX_RANGES));
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_FULL);
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall);
endmodule
